FILE: rtl/six_thruster_effort_mixer_top_macros.svh
// ----------------------------------------------------------------------------
// Six thruster effort mixer assertion macros
// Shorthand for the concurrent checks in the port checker.
// ----------------------------------------------------------------------------
`ifndef SIX_THRUSTER_EFFORT_MIXER_TOP_MACROS_SVH
`define SIX_THRUSTER_EFFORT_MIXER_TOP_MACROS_SVH

// same-cycle implication
`define STEM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/stem_pkg.sv
// ----------------------------------------------------------------------------
// Six thruster effort mixer package
// Widths, codes, microcode word layout and the microprogram itself.
// ----------------------------------------------------------------------------
package stem_pkg;

   // sizes
   localparam int THRUSTER_COUNT = 6;
   localparam int COLUMN_COUNT   = 4;
   localparam int IDX_W          = 3;
   localparam int KIND_W         = 3;
   localparam int CMD_W          = 16;
   localparam int EFF_W          = 24;
   localparam int COEF_W         = 16;
   localparam int MIX_W          = 48;
   localparam int BETA_W         = 17;
   localparam int PWM_W          = 16;

   // port widths
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   // datapath widths
   localparam int M1A_W     = 25;
   localparam int M1B_W     = 17;
   localparam int P1_W      = M1A_W + M1B_W;
   localparam int P2A_W     = 35;
   localparam int P2_W      = P2A_W + CMD_W;
   localparam int ACC_W     = 52;
   localparam int ACC_SHIFT = 31;
   localparam int MIXE_W    = ACC_W - ACC_SHIFT;
   localparam int LIM_W     = MIXE_W + 1;

   // divider
   localparam int DIV_N_W   = 40;
   localparam int DIV_D_W   = 16;
   localparam int DIV_Q_W   = DIV_N_W + 1;
   localparam int DIV_STEPS = DIV_N_W;
   localparam int DIV_CNT_W = 6;
   localparam int SUM_W     = DIV_Q_W + 1;

   // fixed-point constants
   localparam logic [BETA_W-1:0] BETA_ONE     = 17'd65536;
   localparam logic [LIM_W-1:0]  LIMIT_MARGIN = 22'd2048;   // 8.0 in Q8.8
   localparam logic [SUM_W-1:0]  PWM_MAX      = 42'd65535;

   // thruster slots
   localparam logic [IDX_W-1:0] THR_MID_PORT = 3'd2;
   localparam logic [IDX_W-1:0] THR_MID_STAR = 3'd3;

   // sequencer
   localparam int UPC_W = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEAVE    = 3'd0,
      KIND_VECTORED = 3'd1,
      KIND_MANUAL   = 3'd2,
      KIND_SEND     = 3'd3,
      KIND_STOP     = 3'd4
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BETA       = 3'd0,
      CSR_MAX_THRUST = 3'd1,
      CSR_MIX_FPORT  = 3'd2,
      CSR_MIX_FSTAR  = 3'd3,
      CSR_MIX_BPORT  = 3'd4,
      CSR_MIX_BSTAR  = 3'd5,
      CSR_ZERO_PWM   = 3'd6,
      CSR_FULL_PWM   = 3'd7
   } csr_index_type;

   // first multiplier operand pairs
   typedef enum logic [2:0] {
      M1_NONE, M1_WS_CS, M1_WY_CY, M1_WS_CW, M1_EFF_DIFF
   } m1_sel_type;

   // second multiplier command operand
   typedef enum logic [1:0] {
      M2_NONE, M2_SU, M2_YA, M2_SW
   } m2_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_LOAD, ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      EFF_NONE, EFF_HEAVE, EFF_MANUAL, EFF_CLEAR, EFF_MIX
   } eff_op_type;

   typedef enum logic [1:0] {
      CNT_NONE, CNT_CLEAR, CNT_INC
   } cnt_op_type;

   // jump conditions; jump to target when true, else step on; C_KIND dispatches or waits
   typedef enum logic [2:0] {
      C_NEXT, C_ALWAYS, C_KIND, C_DIV_BUSY, C_OUT_BUSY, C_COL_MORE, C_THR_MORE
   } cond_type;

   typedef struct packed {
      logic              accept;
      m1_sel_type        m1;
      m2_sel_type        m2;
      acc_op_type        acc;
      eff_op_type        eff;
      cnt_op_type        cnt;
      logic              div_start;
      logic              emit;
      cond_type          cond;
      logic [UPC_W-1:0]  target;
   } ucode_type;

   // divider handshake
   typedef struct packed {
      logic               start;
      logic               negative;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                      busy;
      logic signed [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

   // microprogram addresses
   localparam logic [UPC_W-1:0] UA_IDLE   = 5'd0;
   localparam logic [UPC_W-1:0] UA_HEAVE  = 5'd1;
   localparam logic [UPC_W-1:0] UA_MANUAL = 5'd2;
   localparam logic [UPC_W-1:0] UA_CLEAR  = 5'd3;
   localparam logic [UPC_W-1:0] UA_S_MUL  = 5'd4;
   localparam logic [UPC_W-1:0] UA_S_DIV  = 5'd5;
   localparam logic [UPC_W-1:0] UA_S_WAIT = 5'd6;
   localparam logic [UPC_W-1:0] UA_S_OUT  = 5'd7;
   localparam logic [UPC_W-1:0] UA_S_EMIT = 5'd8;
   localparam logic [UPC_W-1:0] UA_S_DONE = 5'd9;
   localparam logic [UPC_W-1:0] UA_V_0    = 5'd10;
   localparam logic [UPC_W-1:0] UA_V_1    = 5'd11;
   localparam logic [UPC_W-1:0] UA_V_2    = 5'd12;
   localparam logic [UPC_W-1:0] UA_V_3    = 5'd13;
   localparam logic [UPC_W-1:0] UA_V_4    = 5'd14;
   localparam logic [UPC_W-1:0] UA_V_WR   = 5'd15;
   localparam logic [UPC_W-1:0] UA_V_DONE = 5'd16;

   // control store
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type w;
      w.accept    = 1'b0;
      w.m1        = M1_NONE;
      w.m2        = M2_NONE;
      w.acc       = ACC_NONE;
      w.eff       = EFF_NONE;
      w.cnt       = CNT_NONE;
      w.div_start = 1'b0;
      w.emit      = 1'b0;
      w.cond      = C_NEXT;
      w.target    = UA_IDLE;
      case (addr)
         UA_IDLE: begin
            w.accept = 1'b1;
            w.cnt    = CNT_CLEAR;
            w.cond   = C_KIND;
         end
         UA_HEAVE: begin
            w.eff  = EFF_HEAVE;
            w.cond = C_ALWAYS;
         end
         UA_MANUAL: begin
            w.eff  = EFF_MANUAL;
            w.cond = C_ALWAYS;
         end
         UA_CLEAR: begin
            w.eff = EFF_CLEAR;
         end
         // send loop, one thruster per pass
         UA_S_MUL: begin
            w.m1 = M1_EFF_DIFF;
         end
         UA_S_DIV: begin
            w.div_start = 1'b1;
         end
         UA_S_WAIT: begin
            w.cond   = C_DIV_BUSY;
            w.target = UA_S_WAIT;
         end
         UA_S_OUT: begin
            w.cond   = C_OUT_BUSY;
            w.target = UA_S_OUT;
         end
         UA_S_EMIT: begin
            w.emit   = 1'b1;
            w.cnt    = CNT_INC;
            w.cond   = C_THR_MORE;
            w.target = UA_S_MUL;
         end
         UA_S_DONE: begin
            w.cond = C_ALWAYS;
         end
         // mixing loop, one matrix column per pass
         UA_V_0: begin
            w.m1 = M1_WS_CS;
         end
         UA_V_1: begin
            w.m1 = M1_WY_CY;
            w.m2 = M2_SU;
         end
         UA_V_2: begin
            w.m1  = M1_WS_CW;
            w.m2  = M2_YA;
            w.acc = ACC_LOAD;
         end
         UA_V_3: begin
            w.m2  = M2_SW;
            w.acc = ACC_ADD;
         end
         UA_V_4: begin
            w.acc = ACC_ADD;
         end
         UA_V_WR: begin
            w.eff    = EFF_MIX;
            w.cnt    = CNT_INC;
            w.cond   = C_COL_MORE;
            w.target = UA_V_0;
         end
         UA_V_DONE: begin
            w.cond = C_ALWAYS;
         end
         default: begin
            w.cond = C_ALWAYS;
         end
      endcase
      return w;
   endfunction

   // entry point for an accepted word
   function automatic logic [UPC_W-1:0] dispatch(
      input logic [KIND_W-1:0] kind,
      input logic              trav,
      input logic [IDX_W-1:0]  tgt
   );
      logic [UPC_W-1:0] a;
      a = UA_IDLE;
      case (kind)
         KIND_HEAVE:    a = trav ? UA_HEAVE : UA_IDLE;
         KIND_VECTORED: a = trav ? UA_V_0 : UA_IDLE;
         KIND_MANUAL: begin
            a = (trav && (tgt < IDX_W'(THRUSTER_COUNT))) ? UA_MANUAL : UA_IDLE;
         end
         KIND_SEND:     a = UA_S_MUL;
         KIND_STOP:     a = UA_CLEAR;
         default:       a = UA_IDLE;
      endcase
      return a;
   endfunction

   // matrix column to thruster slot: fport, fstar, bport, bstar
   function automatic logic [IDX_W-1:0] col_slot(input logic [1:0] col);
      return {col[1], 1'b0, col[0]};
   endfunction

endpackage

FILE: rtl/stem_div.sv
// ----------------------------------------------------------------------------
// Serial floor divider
// Restoring divide of a magnitude by a positive divisor, one quotient bit
// per cycle, then a fix-up step that applies the sign with floor rounding.
// ----------------------------------------------------------------------------
module stem_div (
   input  logic                  clock,
   input  logic                  reset,
   input  stem_pkg::div_req_type div_req,
   output stem_pkg::div_rsp_type div_rsp
);
   import stem_pkg::*;

   logic                      busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]        rem_ff, rem_in;
   logic [DIV_N_W-1:0]        quo_ff, quo_in;
   logic [DIV_D_W-1:0]        den_ff;
   logic                      neg_ff;
   logic signed [DIV_Q_W-1:0] result_ff, result_in;

   logic [DIV_D_W:0]   shifted;
   logic [DIV_D_W+1:0] trial;
   logic               take;
   logic [DIV_Q_W-1:0] q_ext;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      take    = !trial[DIV_D_W+1];
      q_ext   = {1'b0, quo_ff};
   end

   // control and datapath next values
   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      result_in = result_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS + 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            if (neg_ff) begin
               result_in = -(q_ext + DIV_Q_W'(rem_ff != '0));
            end else begin
               result_in = q_ext;
            end
         end else begin
            rem_in = take ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
      if (div_req.start) begin
         den_ff <= div_req.divisor;
         neg_ff <= div_req.negative;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = result_ff;

endmodule

FILE: rtl/six_thruster_effort_mixer_top.sv
// ----------------------------------------------------------------------------
// Six thruster effort mixer
// Mixes vectored commands into horizontal thruster efforts, takes heave and
// manual efforts, and turns the six stored efforts into PWM words on send.
//
//   channel | dir | handshake         | word
//   req     | in  | tvalid / tready   | tuser kind, tdata command fields
//   rsp     | out | tvalid / tready   | tdata index and PWM, tlast sixth word
//   csr     | in  | valid / ready     | index, 48-bit data
//
// A microcoded sequencer runs one word at a time. A vectored word takes
// six steps per matrix column on one shared two-stage multiplier. Send
// and stop run the bit-serial divider once per thruster and wait out any
// rsp stall; stop first clears the efforts. Reset is synchronous; it
// clears efforts and loads register defaults.
// ----------------------------------------------------------------------------
module six_thruster_effort_mixer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] traversing, [16:1] surge_cmd, [32:17] yaw_cmd, [48:33] sway_cmd,
   // [64:49] heave_cmd, [67:65] target_thruster, [91:68] manual_value
   input  logic [stem_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [2:0] kind
   input  logic [stem_pkg::KIND_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] thruster_index, [18:3] pwm_value
   output logic [stem_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [stem_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [stem_pkg::CSR_DATA_W-1:0]    csr_data
);
   import stem_pkg::*;

   // configuration registers
   logic [BETA_W-1:0] beta_ff;
   logic [PWM_W-1:0]  max_ff;
   logic [MIX_W-1:0]  mix_ff [COLUMN_COUNT];
   logic [PWM_W-1:0]  zero_ff;
   logic [PWM_W-1:0]  full_ff;

   // latched command
   logic signed [CMD_W-1:0] su_ff, ya_ff, sw_ff, hv_ff;
   logic [IDX_W-1:0]        tgt_ff;
   logic signed [EFF_W-1:0] man_ff;

   // sequencer
   logic [UPC_W-1:0] upc_ff, upc_in;
   ucode_type        uc;
   logic [IDX_W-1:0] idx_ff;
   logic             req_accept;

   // datapath
   logic signed [EFF_W-1:0]  eff_ff [THRUSTER_COUNT];
   logic signed [P1_W-1:0]   p1_ff;
   logic signed [P2_W-1:0]   p2_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [M1A_W-1:0]  m1_a;
   logic signed [M1B_W-1:0]  m1_b;
   logic signed [CMD_W-1:0]  m2_b;
   logic [BETA_W-1:0]        b_sat, ws;
   logic [BETA_W:0]          wy;
   logic signed [M1B_W-1:0]  pwm_span;
   logic [PWM_W-1:0]         mx;
   logic [MIX_W-1:0]         mix_cur;
   logic signed [EFF_W-1:0]  eff_sel;
   logic signed [MIXE_W-1:0] mix_raw;
   logic signed [LIM_W-1:0]  mix_lim;
   logic signed [EFF_W-1:0]  mix_eff;
   logic signed [P1_W-1:0]   p1_abs;

   // divider and output stage
   div_req_type              div_req;
   div_rsp_type              div_rsp;
   logic signed [SUM_W-1:0]  pwm_sum;
   logic [PWM_W-1:0]         pwm_sat;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_idx_ff;
   logic [PWM_W-1:0]         rsp_pwm_ff;
   logic                     rsp_last_ff;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= 17'd32768;
         max_ff  <= 16'd256;
         for (int i = 0; i < COLUMN_COUNT; i++) begin
            mix_ff[i] <= '0;
         end
         zero_ff <= 16'd1500;
         full_ff <= 16'd1900;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BETA:       beta_ff   <= csr_data[BETA_W-1:0];
            CSR_MAX_THRUST: max_ff    <= csr_data[PWM_W-1:0];
            CSR_MIX_FPORT:  mix_ff[0] <= csr_data;
            CSR_MIX_FSTAR:  mix_ff[1] <= csr_data;
            CSR_MIX_BPORT:  mix_ff[2] <= csr_data;
            CSR_MIX_BSTAR:  mix_ff[3] <= csr_data;
            CSR_ZERO_PWM:   zero_ff   <= csr_data[PWM_W-1:0];
            CSR_FULL_PWM:   full_ff   <= csr_data[PWM_W-1:0];
            default: ;
         endcase
      end
   end

   // input word capture
   assign uc         = ucode_rom(upc_ff);
   assign req_tready = uc.accept;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         su_ff  <= req_tdata[16:1];
         ya_ff  <= req_tdata[32:17];
         sw_ff  <= req_tdata[48:33];
         hv_ff  <= req_tdata[64:49];
         tgt_ff <= req_tdata[67:65];
         man_ff <= req_tdata[91:68];
      end
   end

   // step counter and jumps
   always_comb begin
      upc_in = UPC_W'(upc_ff + 1'b1);
      case (uc.cond)
         C_NEXT:     upc_in = UPC_W'(upc_ff + 1'b1);
         C_ALWAYS:   upc_in = uc.target;
         C_KIND: begin
            upc_in = req_accept ? dispatch(req_tuser, req_tdata[0], req_tdata[67:65])
                                : upc_ff;
         end
         C_DIV_BUSY: if (div_rsp.busy) upc_in = uc.target;
         C_OUT_BUSY: if (rsp_valid_ff && !rsp_tready) upc_in = uc.target;
         C_COL_MORE: if (idx_ff != IDX_W'(COLUMN_COUNT - 1)) upc_in = uc.target;
         C_THR_MORE: if (idx_ff != IDX_W'(THRUSTER_COUNT - 1)) upc_in = uc.target;
         default:    upc_in = UA_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
         idx_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         case (uc.cnt)
            CNT_CLEAR: idx_ff <= '0;
            CNT_INC:   idx_ff <= idx_ff + 1'b1;
            default: ;
         endcase
      end
   end

   // derived weights and scale
   always_comb begin
      b_sat    = (beta_ff > BETA_ONE) ? BETA_ONE : beta_ff;
      ws       = BETA_ONE - b_sat;
      wy       = {b_sat, 1'b0};
      pwm_span = $signed({1'b0, full_ff}) - $signed({1'b0, zero_ff});
      mx       = (max_ff == '0) ? PWM_W'(1) : max_ff;
      mix_cur  = mix_ff[idx_ff[1:0]];
      eff_sel  = eff_ff[idx_ff];
   end

   // first multiplier operand select
   always_comb begin
      m1_a = '0;
      m1_b = '0;
      case (uc.m1)
         M1_WS_CS: begin
            m1_a = $signed({{(M1A_W-BETA_W){1'b0}}, ws});
            m1_b = M1B_W'($signed(mix_cur[COEF_W-1:0]));
         end
         M1_WY_CY: begin
            m1_a = $signed({{(M1A_W-BETA_W-1){1'b0}}, wy});
            m1_b = M1B_W'($signed(mix_cur[2*COEF_W-1:COEF_W]));
         end
         M1_WS_CW: begin
            m1_a = $signed({{(M1A_W-BETA_W){1'b0}}, ws});
            m1_b = M1B_W'($signed(mix_cur[3*COEF_W-1:2*COEF_W]));
         end
         M1_EFF_DIFF: begin
            m1_a = M1A_W'(eff_sel);
            m1_b = pwm_span;
         end
         default: ;
      endcase
   end

   // second multiplier operand select
   always_comb begin
      case (uc.m2)
         M2_SU:   m2_b = su_ff;
         M2_YA:   m2_b = ya_ff;
         M2_SW:   m2_b = sw_ff;
         default: m2_b = '0;
      endcase
   end

   // multiplier stages and accumulator
   always_ff @(posedge clock) begin
      if (uc.m1 != M1_NONE) begin
         p1_ff <= m1_a * m1_b;
      end
      if (uc.m2 != M2_NONE) begin
         p2_ff <= $signed(p1_ff[P2A_W-1:0]) * m2_b;
      end
      case (uc.acc)
         ACC_LOAD: acc_ff <= ACC_W'(p2_ff);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(p2_ff);
         default: ;
      endcase
   end

   // floor to Q16.8 and thrust limit
   always_comb begin
      mix_raw = acc_ff[ACC_W-1:ACC_SHIFT];
      if (LIM_W'(mix_raw) > $signed({{(LIM_W-PWM_W){1'b0}}, mx})) begin
         mix_lim = $signed({{(LIM_W-PWM_W){1'b0}}, mx}) - $signed(LIMIT_MARGIN);
      end else begin
         mix_lim = LIM_W'(mix_raw);
      end
      mix_eff = EFF_W'(mix_lim);
   end

   // stored efforts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THRUSTER_COUNT; i++) begin
            eff_ff[i] <= '0;
         end
      end else begin
         case (uc.eff)
            EFF_HEAVE: begin
               eff_ff[THR_MID_PORT] <= EFF_W'(hv_ff);
               eff_ff[THR_MID_STAR] <= EFF_W'(hv_ff);
            end
            EFF_MANUAL: eff_ff[tgt_ff] <= man_ff;
            EFF_CLEAR: begin
               for (int i = 0; i < THRUSTER_COUNT; i++) begin
                  eff_ff[i] <= '0;
               end
            end
            EFF_MIX: eff_ff[col_slot(idx_ff[1:0])] <= mix_eff;
            default: ;
         endcase
      end
   end

   // divide effort times span by the thrust scale
   always_comb begin
      p1_abs           = p1_ff[P1_W-1] ? -p1_ff : p1_ff;
      div_req.start    = uc.div_start;
      div_req.negative = p1_ff[P1_W-1];
      div_req.dividend = p1_abs[DIV_N_W-1:0];
      div_req.divisor  = mx;
   end

   stem_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // offset and saturate
   always_comb begin
      pwm_sum = $signed({{(SUM_W-PWM_W){1'b0}}, zero_ff}) + SUM_W'(div_rsp.quotient);
      if (pwm_sum < 0) begin
         pwm_sat = '0;
      end else if (pwm_sum > $signed(PWM_MAX)) begin
         pwm_sat = '1;
      end else begin
         pwm_sat = pwm_sum[PWM_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (uc.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (uc.emit) begin
         rsp_idx_ff  <= idx_ff;
         rsp_pwm_ff  <= pwm_sat;
         rsp_last_ff <= (idx_ff == IDX_W'(THRUSTER_COUNT - 1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-PWM_W-IDX_W){1'b0}}, rsp_pwm_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/stem_checker.sv
// ----------------------------------------------------------------------------
// Six thruster effort mixer port checker
// Watches the top level ports: result order, framing, output stalls, no req accept mid-send, and reset.
// ----------------------------------------------------------------------------
`include "six_thruster_effort_mixer_top_macros.svh"

module stem_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [stem_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);
   import stem_pkg::*;

   logic [IDX_W-1:0] exp_idx_ff, exp_idx_in;

   // expected thruster index of the next word
   always_comb begin
      exp_idx_in = exp_idx_ff;
      if (rsp_tvalid && rsp_tready) begin
         exp_idx_in = rsp_tlast ? '0 : exp_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else begin
         exp_idx_ff <= exp_idx_in;
      end
   end

   `STEM_ASSERT_SAME(a_index_order, clock, reset, rsp_tvalid, rsp_tdata[IDX_W-1:0] == exp_idx_ff, "rsp thruster index out of order")
   `STEM_ASSERT_SAME(a_last_on_sixth, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[IDX_W-1:0] == IDX_W'(THRUSTER_COUNT - 1)), "rsp tlast not on sixth word")
   `STEM_ASSERT_SAME(a_no_accept_mid_send, clock, reset, rsp_tvalid && !rsp_tlast, !(req_tvalid && req_tready), "req accepted during a send")
   `STEM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")
   `STEM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid, "rsp valid after reset")

endmodule

bind six_thruster_effort_mixer_top stem_checker u_stem_checker (.*);
